FILE: hdl/lct_pkg.sv
// Shared constants and types for the LRU cache key tracker.
// No dependencies; lct_csr and the top level import this package.
package lct_pkg;

   // Build-time defaults handed to the top-level parameters
   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_KEY_BITS    = 32;

   // Fixed widths of the register and the result counters
   localparam int CAP_W   = 7;
   localparam int TOTAL_W = 32;

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Configuration port geometry: one 32-bit register per word
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [CSR_ADDR_W-3:0] reg_idx_type;

   // Register indexes
   localparam reg_idx_type REG_CAPACITY = reg_idx_type'(0);

endpackage

FILE: hdl/lct_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the key store and the recency rank store.
module lct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lct_csr.sv
// APB-style configuration register block: holds the capacity register.
// Depends on lct_pkg for register widths, address map and reset value.
module lct_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lct_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lct_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lct_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output logic [lct_pkg::CAP_W-1:0]        capacity
);
   import lct_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   reg_idx_type      reg_idx;
   logic             wr_strobe;

   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign wr_strobe = psel & penable & pwrite;
   assign pready    = 1'b1;

   // Decode register index for reads and writes
   always_comb begin
      cap_in = cap_ff;
      prdata = '0;
      unique case (reg_idx)
         REG_CAPACITY: begin
            prdata = CSR_DATA_W'(cap_ff);
            if (wr_strobe) begin
               cap_in = pwdata[CAP_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // Hold the register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign capacity = cap_ff;

endmodule

FILE: hdl/lru_cache_key_tracker.sv
// Fully associative LRU cache directory: keys and recency ranks live in two RAMs.
// Each request runs a key scan over the held slots, a decide step, then a rank rewrite pass.
// A new request is taken only after the last result, in the strobe cycle; no rsp stall.
// Reset (synchronous) empties the directory, clears both totals, sets capacity to 64;
// the RAMs need no clearing pass, since only slots below the fill level are read.
module lru_cache_key_tracker #(
   parameter int MAX_ENTRIES = lct_pkg::DEF_MAX_ENTRIES,
   parameter int KEY_BITS    = lct_pkg::DEF_KEY_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                start,
   output logic                                busy,
   input  logic signed [KEY_BITS-1:0]          req_lookup_key,
   // Result channel
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic                                rsp_evicted_valid,
   output logic signed [KEY_BITS-1:0]          rsp_evicted_key,
   output logic [lct_pkg::TOTAL_W-1:0]         rsp_hit_total,
   output logic [lct_pkg::TOTAL_W-1:0]         rsp_miss_total,
   output logic [$clog2(MAX_ENTRIES+1)-1:0]    rsp_fill_level,
   // Configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lct_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [lct_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [lct_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import lct_pkg::*;

   localparam int IDX_W  = $clog2(MAX_ENTRIES);
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE
   } state_type;

   // Registers and next values
   state_type           state_ff, state_in;
   logic                busy_ff, busy_in;
   logic                strobe_ff, strobe_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    found_idx_ff, found_idx_in;
   logic [RANK_W-1:0]   found_rank_ff, found_rank_in;
   logic [IDX_W-1:0]    vict_idx_ff, vict_idx_in;
   logic [KEY_BITS-1:0] vict_key_ff, vict_key_in;
   logic [IDX_W-1:0]    target_ff, target_in;
   logic [RANK_W-1:0]   limit_ff, limit_in;
   logic                age_all_ff, age_all_in;
   logic [CNT_W-1:0]    upd_cnt_ff, upd_cnt_in;
   logic                hit_ff, hit_in;
   logic                ev_valid_ff, ev_valid_in;
   logic [KEY_BITS-1:0] ev_key_ff, ev_key_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [TOTAL_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [TOTAL_W-1:0]  miss_cnt_ff, miss_cnt_in;

   // Memory ports
   logic                key_wr_en;
   logic [IDX_W-1:0]    key_wr_addr;
   logic [KEY_BITS-1:0] key_wr_data;
   logic                key_rd_en;
   logic [KEY_BITS-1:0] key_rd;
   logic                rank_wr_en;
   logic [IDX_W-1:0]    rank_wr_addr;
   logic [RANK_W-1:0]   rank_wr_data;
   logic                rank_rd_en;
   logic [RANK_W-1:0]   rank_rd;
   logic [IDX_W-1:0]    rd_addr;

   // Misc datapath
   logic [CAP_W-1:0]    capacity;
   logic [CMP_W-1:0]    cap_eff;
   logic                room;
   logic [CNT_W-1:0]    occ_m1;
   logic [CNT_W-1:0]    pass_len;
   logic                issue;

   lct_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   lct_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (key_rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   lct_ram #(.WIDTH(RANK_W), .DEPTH(MAX_ENTRIES)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (rank_wr_addr),
      .wr_data (rank_wr_data),
      .rd_en   (rank_rd_en),
      .rd_addr (rd_addr),
      .rd_data (rank_rd)
   );

   // Clamp capacity to 1..MAX_ENTRIES and check for a free slot
   always_comb begin
      if (capacity == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
         cap_eff = CMP_W'(MAX_ENTRIES);
      end else begin
         cap_eff = CMP_W'(capacity);
      end
   end

   assign room     = CMP_W'(occ_ff) < cap_eff;
   assign occ_m1   = occ_ff - CNT_W'(1);
   assign pass_len = (state_ff == ST_SCAN) ? occ_ff : upd_cnt_ff;
   assign issue    = idx_ff < pass_len;
   assign rd_addr  = idx_ff[IDX_W-1:0];

   // Next-state and datapath logic
   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      strobe_in     = 1'b0;
      key_in        = key_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_rank_in = found_rank_ff;
      vict_idx_in   = vict_idx_ff;
      vict_key_in   = vict_key_ff;
      target_in     = target_ff;
      limit_in      = limit_ff;
      age_all_in    = age_all_ff;
      upd_cnt_in    = upd_cnt_ff;
      hit_in        = hit_ff;
      ev_valid_in   = ev_valid_ff;
      ev_key_in     = ev_key_ff;
      occ_in        = occ_ff;
      hit_cnt_in    = hit_cnt_ff;
      miss_cnt_in   = miss_cnt_ff;
      key_wr_en     = 1'b0;
      key_wr_addr   = target_ff;
      key_wr_data   = key_ff;
      key_rd_en     = 1'b0;
      rank_wr_en    = 1'b0;
      rank_wr_addr  = pend_idx_ff;
      rank_wr_data  = '0;
      rank_rd_en    = 1'b0;

      unique case (state_ff)
         // Take a new request
         ST_IDLE: begin
            if (start) begin
               key_in   = $unsigned(req_lookup_key);
               idx_in   = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               busy_in  = 1'b1;
               state_in = ST_SCAN;
            end
         end

         // Read every held slot; look for the key and the least recent slot
         ST_SCAN: begin
            key_rd_en   = issue;
            rank_rd_en  = issue;
            pend_in     = issue;
            pend_idx_in = idx_ff[IDX_W-1:0];
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if (key_rd == key_ff) begin
                  found_in      = 1'b1;
                  found_idx_in  = pend_idx_ff;
                  found_rank_in = rank_rd;
               end
               if (rank_rd == occ_m1[RANK_W-1:0]) begin
                  vict_idx_in = pend_idx_ff;
                  vict_key_in = key_rd;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_DECIDE;
            end
         end

         // Pick hit, insert or evict; store the new key on a miss
         ST_DECIDE: begin
            idx_in   = '0;
            pend_in  = 1'b0;
            state_in = ST_UPDATE;
            if (found_ff) begin
               hit_in      = 1'b1;
               ev_valid_in = 1'b0;
               ev_key_in   = '0;
               hit_cnt_in  = (hit_cnt_ff == '1) ? hit_cnt_ff : hit_cnt_ff + TOTAL_W'(1);
               target_in   = found_idx_ff;
               limit_in    = found_rank_ff;
               age_all_in  = 1'b0;
               upd_cnt_in  = occ_ff;
            end else begin
               hit_in      = 1'b0;
               miss_cnt_in = (miss_cnt_ff == '1) ? miss_cnt_ff : miss_cnt_ff + TOTAL_W'(1);
               key_wr_en   = 1'b1;
               if (room) begin
                  ev_valid_in = 1'b0;
                  ev_key_in   = '0;
                  target_in   = occ_ff[IDX_W-1:0];
                  key_wr_addr = occ_ff[IDX_W-1:0];
                  limit_in    = '0;
                  age_all_in  = 1'b1;
                  upd_cnt_in  = occ_ff + CNT_W'(1);
                  occ_in      = occ_ff + CNT_W'(1);
               end else begin
                  ev_valid_in = 1'b1;
                  ev_key_in   = vict_key_ff;
                  target_in   = vict_idx_ff;
                  key_wr_addr = vict_idx_ff;
                  limit_in    = occ_m1[RANK_W-1:0];
                  age_all_in  = 1'b0;
                  upd_cnt_in  = occ_ff;
               end
            end
         end

         // Rewrite ranks: target goes to zero, younger slots age by one
         ST_UPDATE: begin
            rank_rd_en  = issue;
            pend_in     = issue;
            pend_idx_in = idx_ff[IDX_W-1:0];
            if (issue) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               rank_wr_en = 1'b1;
               if (pend_idx_ff == target_ff) begin
                  rank_wr_data = '0;
               end else if (age_all_ff || (rank_rd < limit_ff)) begin
                  rank_wr_data = rank_rd + RANK_W'(1);
               end else begin
                  rank_wr_data = rank_rd;
               end
            end
            if (!issue && !pend_ff) begin
               busy_in   = 1'b0;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         busy_ff     <= 1'b0;
         strobe_ff   <= 1'b0;
         idx_ff      <= '0;
         pend_ff     <= 1'b0;
         found_ff    <= 1'b0;
         occ_ff      <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         strobe_ff     <= strobe_in;
         key_ff        <= key_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         pend_idx_ff   <= pend_idx_in;
         found_ff      <= found_in;
         found_idx_ff  <= found_idx_in;
         found_rank_ff <= found_rank_in;
         vict_idx_ff   <= vict_idx_in;
         vict_key_ff   <= vict_key_in;
         target_ff     <= target_in;
         limit_ff      <= limit_in;
         age_all_ff    <= age_all_in;
         upd_cnt_ff    <= upd_cnt_in;
         hit_ff        <= hit_in;
         ev_valid_ff   <= ev_valid_in;
         ev_key_ff     <= ev_key_in;
         occ_ff        <= occ_in;
         hit_cnt_ff    <= hit_cnt_in;
         miss_cnt_ff   <= miss_cnt_in;
      end
   end

   // Drive the ports
   assign busy              = busy_ff;
   assign rsp_strobe        = strobe_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_key   = $signed(ev_key_ff);
   assign rsp_hit_total     = hit_cnt_ff;
   assign rsp_miss_total    = miss_cnt_ff;
   assign rsp_fill_level    = occ_ff;

   // Fill level never exceeds the directory size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(MAX_ENTRIES))
      else $error("fill level above directory size");

   // Rank read-modify-write never reads and writes the same slot in one cycle
   a_rank_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (rank_wr_en && rank_rd_en) |-> (rank_wr_addr != rd_addr))
      else $error("rank write and read collide");

   // A result only follows the end of the rank rewrite pass
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == ST_UPDATE))
      else $error("result strobe outside rank update");

   // The key store is written only when deciding a miss
   a_key_write: assert property (@(posedge clock) disable iff (reset)
      key_wr_en |-> (state_ff == ST_DECIDE && !found_ff))
      else $error("key store written outside a miss");

endmodule
